FILE: hdl/hpes_pkg.sv
`timescale 1ns / 1ps
package hpes_pkg;

   localparam int PAD_COUNT = 16;
   localparam int IDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
   localparam int CNT_W = $clog2(PAD_COUNT + 1);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_PENDING = 3'd1;
   localparam logic [2:0] PH_KICK    = 3'd2;
   localparam logic [2:0] PH_GAP     = 3'd3;
   localparam logic [2:0] PH_SUSTAIN = 3'd4;

   localparam logic [1:0] MODE_KICK     = 2'd0;
   localparam logic [1:0] MODE_PRESSURE = 2'd1;
   localparam logic [1:0] MODE_STOP     = 2'd2;
   localparam logic [1:0] MODE_TICK     = 2'd3;

   localparam logic [1:0] ST_WRITE   = 2'd0;
   localparam logic [1:0] ST_QUEUED  = 2'd1;
   localparam logic [1:0] ST_DROPPED = 2'd2;

   localparam logic [1:0] DK_OFF = 2'd0;
   localparam logic [1:0] DK_ON  = 2'd1;
   localparam logic [1:0] DK_PWM = 2'd2;

   localparam logic [2:0] CSR_MAX_VOICES = 3'd0;
   localparam logic [2:0] CSR_KICK_LEN   = 3'd1;
   localparam logic [2:0] CSR_OD_LEN     = 3'd2;
   localparam logic [2:0] CSR_GAP_LEN    = 3'd3;
   localparam logic [2:0] CSR_STAGGER    = 3'd4;
   localparam logic [2:0] CSR_ATTACK     = 3'd5;
   localparam logic [2:0] CSR_RELEASE    = 3'd6;
   localparam logic [2:0] CSR_SUS_EN     = 3'd7;

   // ceil(2^39 / 3175): x * 65536 / 12700 == (x * RECIP_3175) >> 25 for x < 16384
   localparam logic [27:0] RECIP_3175 = 28'd173151438;

   // per-pad record: phase, time, velocity, overdrive, pressure, duty
   typedef struct packed {
      logic [2:0]  phase;
      logic [31:0] ptime;
      logic [6:0]  vel;
      logic        od;
      logic [6:0]  press;
      logic [15:0] duty;
   } pad_rec_type;

   localparam int REC_W = $bits(pad_rec_type);

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  pad;
      logic [1:0]  kind;
      logic [11:0] count;
      logic        last;
   } rsp_type;

   // floor(x * 65536 / 12700) by reciprocal multiply
   function automatic logic [16:0] q16_scale(input logic [13:0] x);
      logic [41:0] p;
      p = 42'(x) * 42'(RECIP_3175);
      return p[41:25];
   endfunction

   // kick level after overdrive, Q1.16
   function automatic logic [16:0] kick_level(input logic [6:0] v);
      return q16_scale(14'd8255 + 14'd35 * 14'(v));
   endfunction

   function automatic logic [16:0] sus_target(input logic [6:0] v, input logic [6:0] a);
      return q16_scale(14'd18 * 14'(v) + 14'd42 * 14'(a));
   endfunction

endpackage

FILE: hdl/hpes_ram.sv
`timescale 1ns / 1ps
module hpes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: hdl/hpes_level.sv
`timescale 1ns / 1ps
// Q1.16 level to motor drive code
module hpes_level (
   input  logic [16:0] level,
   output logic [1:0]  kind,
   output logic [11:0] count
);
   import hpes_pkg::*;
   logic [28:0] prod;
   logic [11:0] c;
   always_comb begin
      prod = 29'(level) * 29'd4095;
      c = prod[27:16];
      kind = DK_PWM;
      count = 12'd0;
      if (level == 17'd0) begin
         kind = DK_OFF;
      end else if (level[16]) begin
         kind = DK_ON;
      end else if (c < 12'd1) begin
         count = 12'd1;
      end else if (c > 12'd4094) begin
         count = 12'd4094;
      end else begin
         count = c;
      end
   end
endmodule

FILE: hdl/haptic_pad_envelope_scheduler_core.sv
`timescale 1ns / 1ps
// Channel  | Dir | Transaction
// req_*    | in  | tdata {value[13:7], pad[6:2], mode[1:0]}
// rsp_*    | out | tdata {low_ticks[20:9], drive_kind[8:7], pad_out[6:2], status[1:0]}, tlast
// csr_*    | in  | index 0..7, data 16 bits
// Pad state lives in one 16-entry RAM (registered read). A busy bit per pad
// in flops gives the voice count at once; a written bit per pad makes
// unwritten entries read as zero.
// A tick walks every pad (read, then modify and write back) before the next
// request is taken; kick/pressure/stop visit one pad.
// Each result waits in a hold register until the next result or the end of
// the walk decides tlast, then goes through the level stage into rsp.
// The walk stalls only while a new result finds hold and rsp both full.
// Reset (synchronous) idles all pads and loads register defaults.
// Config only while no request is in flight.
module haptic_pad_envelope_scheduler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // mode[1:0], pad[6:2], value[13:7]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status[1:0], pad_out[6:2], drive_kind[8:7], low_ticks[20:9]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import hpes_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_EXEC = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   // result waiting for its tlast decision; level still undecoded
   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  pad;
      logic [16:0] level;
   } hold_type;

   state_type state_ff, state_in;

   logic [4:0]  max_voices_ff;
   logic [7:0]  kick_len_ff, od_len_ff, gap_len_ff, stagger_ff;
   logic [15:0] attack_ff, release_ff;
   logic        sus_en_ff;

   logic [1:0]  mode_ff;
   logic [4:0]  pad_ff;
   logic [6:0]  value_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [31:0] now_ff, slot_ff;
   logic [PAD_COUNT-1:0] busy_ff;   // non-idle per pad
   logic [PAD_COUNT-1:0] wr_ff;     // entry written since reset
   logic        rd_valid_ff;

   hold_type    hold_ff;
   logic        hold_v_ff, hold_v_in;
   rsp_type     out_ff, out_in;
   logic        out_v_ff;

   logic        ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   pad_rec_type ram_wd, ram_rd, rec;

   hpes_ram #(.WIDTH(REC_W), .DEPTH(PAD_COUNT)) u_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wd),
      .raddr(ram_raddr), .rdata(ram_rd));

   always_comb rec = rd_valid_ff ? ram_rd : '0;

   // level converter on the hold register
   logic [1:0]  lvl_kind;
   logic [11:0] lvl_count;
   hpes_level u_lvl (.level(hold_ff.level), .kind(lvl_kind), .count(lvl_count));

   logic [CNT_W-1:0] active;
   always_comb begin
      active = '0;
      for (int i = 0; i < PAD_COUNT; i++) active = active + CNT_W'(busy_ff[i]);
   end

   // execution of one pad record
   pad_rec_type nrec;
   logic        emit;
   hold_type    res;
   logic [31:0] el, earliest, slot_in;
   logic [16:0] tgt, cur, prev;
   logic        od_end;
   logic        pad_ok;
   logic [IDX_W-1:0] tgt_idx;

   always_comb begin
      pad_ok = (pad_ff >= 5'd1) && (32'(pad_ff) <= 32'(PAD_COUNT));
      tgt_idx = IDX_W'(pad_ff - 5'd1);
   end

   always_comb begin
      nrec = rec;
      emit = 1'b0;
      res.status = ST_WRITE;
      res.pad = (mode_ff == MODE_TICK) ? 5'(idx_ff) + 5'd1 : pad_ff;
      res.level = '0;
      slot_in = slot_ff;
      el = now_ff - rec.ptime;
      earliest = (slot_ff > now_ff) ? slot_ff : now_ff;
      tgt = sus_target(rec.vel, rec.press);
      prev = {1'b0, rec.duty};
      cur = prev;
      od_end = 1'b0;
      if (mode_ff == MODE_TICK) begin
         unique case (rec.phase)
            PH_PENDING: begin
               if (now_ff >= rec.ptime) begin
                  nrec.phase = PH_KICK; nrec.ptime = now_ff; nrec.od = 1'b1;
                  nrec.press = '0; nrec.duty = '0;
                  emit = 1'b1; res.level = 17'h10000;
               end
            end
            PH_KICK: begin
               if (rec.od && el >= 32'(od_len_ff)) begin
                  nrec.od = 1'b0; od_end = 1'b1;
               end
               // kick end supersedes the overdrive-end level
               if (el >= 32'(kick_len_ff)) begin
                  nrec.phase = PH_GAP; nrec.ptime = now_ff;
                  emit = 1'b1; res.level = '0;
               end else if (od_end) begin
                  emit = 1'b1; res.level = kick_level(rec.vel);
               end
            end
            PH_GAP: begin
               if (el >= 32'(gap_len_ff)) begin
                  if (sus_en_ff) begin
                     nrec.phase = PH_SUSTAIN; nrec.duty = '0;
                  end else begin
                     nrec.phase = PH_IDLE;
                  end
               end
            end
            PH_SUSTAIN: begin
               if (tgt > cur) begin
                  cur = (tgt - cur <= 17'(attack_ff)) ? tgt : cur + 17'(attack_ff);
               end else if (tgt < cur) begin
                  cur = (cur - tgt <= 17'(release_ff)) ? tgt : cur - 17'(release_ff);
               end
               nrec.duty = cur[15:0];
               if (((cur > prev) ? cur - prev : prev - cur) > 17'd65) begin
                  emit = 1'b1; res.level = cur;
               end
            end
            default: ;
         endcase
      end else begin
         unique case (mode_ff)
            MODE_KICK: begin
               emit = 1'b1;
               if (rec.phase == PH_IDLE && active >= CNT_W'(max_voices_ff)) begin
                  res.status = ST_DROPPED;
               end else if (earliest <= now_ff) begin
                  nrec.phase = PH_KICK; nrec.ptime = now_ff; nrec.vel = value_ff;
                  nrec.od = 1'b1; nrec.press = '0; nrec.duty = '0;
                  res.level = 17'h10000;
                  slot_in = now_ff + 32'(stagger_ff);
               end else begin
                  nrec.phase = PH_PENDING; nrec.ptime = earliest; nrec.vel = value_ff;
                  slot_in = earliest + 32'(stagger_ff);
                  res.status = ST_QUEUED;
               end
            end
            MODE_PRESSURE: nrec.press = value_ff;
            MODE_STOP: begin
               if (rec.phase != PH_IDLE) begin
                  nrec.phase = PH_IDLE; emit = 1'b1; res.level = '0;
               end
            end
            default: ;
         endcase
      end
   end

   logic emit_ok;
   always_comb emit_ok = emit && (mode_ff == MODE_TICK || pad_ok);

   logic last_pad;
   always_comb last_pad = (idx_ff == IDX_W'(PAD_COUNT - 1));

   logic req_acc;
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      req_acc = req_tvalid && req_tready;
   end

   logic out_free;
   always_comb out_free = !out_v_ff || rsp_tready;

   // a new result needs the hold register, which empties only into rsp
   logic can_exec;
   always_comb can_exec = !hold_v_ff || out_free || !emit_ok;

   logic load, move;
   always_comb begin
      load = (state_ff == S_EXEC) && can_exec && emit_ok;
      move = hold_v_ff && out_free && (load || state_ff == S_EMIT);
      hold_v_in = hold_v_ff;
      if (load) hold_v_in = 1'b1;
      else if (move) hold_v_in = 1'b0;
   end

   always_comb begin
      out_in.status = hold_ff.status;
      out_in.pad = hold_ff.pad;
      out_in.kind = DK_OFF;
      out_in.count = '0;
      if (hold_ff.status == ST_WRITE) begin
         out_in.kind = lvl_kind;
         out_in.count = lvl_count;
      end
      out_in.last = (state_ff == S_EMIT);
   end

   always_comb begin
      state_in = state_ff;
      ram_we = 1'b0;
      ram_waddr = (mode_ff == MODE_TICK) ? idx_ff : tgt_idx;
      ram_raddr = (state_ff == S_IDLE) ? IDX_W'(req_tdata[6:2] - 5'd1)
                  : ((mode_ff == MODE_TICK) ? idx_ff : tgt_idx);
      ram_wd = nrec;
      unique case (state_ff)
         S_IDLE: if (req_acc) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: if (can_exec) begin
            ram_we = (mode_ff == MODE_TICK) || pad_ok;
            if (mode_ff == MODE_TICK && !last_pad) state_in = S_READ;
            else state_in = S_EMIT;
         end
         S_EMIT: if (!hold_v_ff || out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         max_voices_ff <= 5'd16; kick_len_ff <= 8'd45; od_len_ff <= 8'd10;
         gap_len_ff <= 8'd8; stagger_ff <= 8'd15; attack_ff <= 16'd1311;
         release_ff <= 16'd197; sus_en_ff <= 1'b1;
         now_ff <= '0; slot_ff <= '0; busy_ff <= '0; wr_ff <= '0;
         hold_v_ff <= 1'b0; out_v_ff <= 1'b0; rd_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         hold_v_ff <= hold_v_in;
         if (out_free) out_v_ff <= move;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MAX_VOICES: max_voices_ff <= csr_wdata[4:0];
               CSR_KICK_LEN:   kick_len_ff <= csr_wdata[7:0];
               CSR_OD_LEN:     od_len_ff <= csr_wdata[7:0];
               CSR_GAP_LEN:    gap_len_ff <= csr_wdata[7:0];
               CSR_STAGGER:    stagger_ff <= csr_wdata[7:0];
               CSR_ATTACK:     attack_ff <= csr_wdata;
               CSR_RELEASE:    release_ff <= csr_wdata;
               CSR_SUS_EN:     sus_en_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: if (req_acc) begin
               if (req_tdata[1:0] == MODE_TICK) now_ff <= now_ff + 32'd1;
               idx_ff <= '0;
               rd_valid_ff <= 1'b0;
            end
            S_READ: rd_valid_ff <= wr_ff[ram_raddr];
            S_EXEC: if (can_exec) begin
               if (ram_we) begin
                  wr_ff[ram_waddr] <= 1'b1;
                  busy_ff[ram_waddr] <= (nrec.phase != PH_IDLE);
               end
               if (mode_ff != MODE_TICK && pad_ok) slot_ff <= slot_in;
               if (mode_ff == MODE_TICK) idx_ff <= idx_ff + IDX_W'(1);
            end
            S_EMIT: ;
            default: ;
         endcase
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_acc) begin
         mode_ff <= req_tdata[1:0];
         pad_ff <= req_tdata[6:2];
         value_ff <= req_tdata[13:7];
      end
      if (load) hold_ff <= res;
      if (move) out_ff <= out_in;
   end

   always_comb begin
      rsp_tvalid = out_v_ff;
      rsp_tdata = {3'd0, out_ff.count, out_ff.kind, out_ff.pad, out_ff.status};
      rsp_tlast = out_ff.last;
   end
endmodule
